/* rtl/fcsd_pkg.sv */
// package: shared types and constants for the floor/ceil signed divider
`default_nettype none
package fcsd_pkg;
    localparam logic [1:0] FN_FLOOR_Q = 2'd0;
    localparam logic [1:0] FN_FLOOR_R = 2'd1;
    localparam logic [1:0] FN_CEIL_Q  = 2'd2;
    localparam logic [1:0] FN_RSVD    = 2'd3;
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    // per-transaction control carried down the cell chain
    typedef struct packed {
        logic       vld;
        logic [1:0] func;
        logic       a_neg;
        logic       b_neg;
        logic       b_zero;
        logic       ovf;
    } t_ctl;
endpackage
`default_nettype wire

/* rtl/fcsd_cell.sv */
// cell: one restoring division step on unsigned magnitudes
`default_nettype none
module fcsd_cell #(
    parameter int WIDTH = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire fcsd_pkg::t_ctl    i_ctl,
    input  wire logic [WIDTH-1:0]  i_rem,
    input  wire logic [WIDTH-1:0]  i_quo,
    input  wire logic [WIDTH-1:0]  i_den,
    output fcsd_pkg::t_ctl         o_ctl,
    output logic [WIDTH-1:0]       o_rem,
    output logic [WIDTH-1:0]       o_quo,
    output logic [WIDTH-1:0]       o_den
);
    import fcsd_pkg::*;
    logic [WIDTH:0] n_shift;
    logic [WIDTH:0] n_diff;
    logic           n_ge;
    always_comb begin
        n_shift = {i_rem, i_quo[WIDTH-1]};
        n_diff  = n_shift - {1'b0, i_den};
        n_ge    = ~n_diff[WIDTH];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.vld <= 1'b0;
        end else begin
            o_ctl.vld <= i_ctl.vld;
        end
        o_ctl.func   <= i_ctl.func;
        o_ctl.a_neg  <= i_ctl.a_neg;
        o_ctl.b_neg  <= i_ctl.b_neg;
        o_ctl.b_zero <= i_ctl.b_zero;
        o_ctl.ovf    <= i_ctl.ovf;
        o_rem <= n_ge ? n_diff[WIDTH-1:0] : n_shift[WIDTH-1:0];
        o_quo <= {i_quo[WIDTH-2:0], n_ge};
        o_den <= i_den;
    end
endmodule
`default_nettype wire

/* rtl/floor_ceil_signed_divider_unit.sv */
// top level: pipelined floor/ceil signed divider built from a chain of cells
// One transaction is accepted every cycle (busy stays low). Each result reaches
// the outputs through one input register, WIDTH cells of one quotient bit each,
// and one fix-up register. The receiver cannot stall.
`default_nettype none
module floor_ceil_signed_divider_unit #(
    parameter int WIDTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_func,
    input  wire logic [63:0] i_dividend,
    input  wire logic [63:0] i_divisor,
    output logic             o_strobe,
    output logic [63:0]      o_result,
    output logic [1:0]       o_status
);
    import fcsd_pkg::*;
    logic signed [WIDTH-1:0] n_a, n_b;
    t_ctl n_ctl;
    t_ctl             c_ctl [WIDTH+1];
    logic [WIDTH-1:0] c_rem [WIDTH+1];
    logic [WIDTH-1:0] c_quo [WIDTH+1];
    logic [WIDTH-1:0] c_den [WIDTH+1];
    logic [WIDTH-1:0] n_q, n_r, n_res;
    logic [1:0]       n_st;
    logic             n_rnz;

    assign busy = 1'b0;
    always_comb begin
        n_a = i_dividend[WIDTH-1:0];
        n_b = i_divisor[WIDTH-1:0];
        n_ctl.vld    = start;
        n_ctl.func   = i_func;
        n_ctl.a_neg  = n_a[WIDTH-1];
        n_ctl.b_neg  = n_b[WIDTH-1];
        n_ctl.b_zero = (n_b == '0);
        n_ctl.ovf    = (n_a == {1'b1, {(WIDTH-1){1'b0}}}) && (n_b == '1);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            c_ctl[0].vld <= 1'b0;
        end else begin
            c_ctl[0].vld <= n_ctl.vld;
        end
        c_ctl[0].func   <= n_ctl.func;
        c_ctl[0].a_neg  <= n_ctl.a_neg;
        c_ctl[0].b_neg  <= n_ctl.b_neg;
        c_ctl[0].b_zero <= n_ctl.b_zero;
        c_ctl[0].ovf    <= n_ctl.ovf;
        c_rem[0] <= '0;
        c_quo[0] <= n_a[WIDTH-1] ? -n_a : n_a;
        c_den[0] <= n_b[WIDTH-1] ? -n_b : n_b;
    end
    for (genvar g = 0; g < WIDTH; g++) begin : g_cell
        fcsd_cell #(.WIDTH(WIDTH)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_ctl(c_ctl[g]), .i_rem(c_rem[g]), .i_quo(c_quo[g]), .i_den(c_den[g]),
            .o_ctl(c_ctl[g+1]), .o_rem(c_rem[g+1]), .o_quo(c_quo[g+1]),
            .o_den(c_den[g+1])
        );
    end
    always_comb begin
        t_ctl c;
        c = c_ctl[WIDTH];
        n_q = (c.a_neg ^ c.b_neg) ? -c_quo[WIDTH] : c_quo[WIDTH];
        n_r = c.a_neg ? -c_rem[WIDTH] : c_rem[WIDTH];
        n_rnz = (c_rem[WIDTH] != '0);
        n_res = '0;
        n_st = ST_OK;
        if (c.func == FN_RSVD) begin
            n_res = '0;
        end else if (c.b_zero) begin
            n_st = ST_DIV0;
        end else if (c.ovf) begin
            if (c.func != FN_FLOOR_R) begin
                n_res = {1'b0, {(WIDTH-1){1'b1}}};
                n_st = ST_OVF;
            end
        end else begin
            case (c.func)
                FN_FLOOR_Q: n_res = (n_rnz && (c.a_neg != c.b_neg)) ? n_q - 1'b1 : n_q;
                FN_FLOOR_R: n_res = (n_rnz && (c.a_neg != c.b_neg))
                                    ? n_r + (c.b_neg ? -c_den[WIDTH] : c_den[WIDTH]) : n_r;
                FN_CEIL_Q:  n_res = (n_rnz && (c.a_neg == c.b_neg)) ? n_q + 1'b1 : n_q;
                default:    n_res = '0;
            endcase
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= c_ctl[WIDTH].vld;
        end
        o_result <= 64'($signed(n_res));
        o_status <= n_st;
    end

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe)
        else $error("strobe after reset");
    a_div0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status == ST_DIV0 |-> o_result == 64'd0)
        else $error("div0 result nonzero");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_ctl[0].vld |-> ##(WIDTH) c_ctl[WIDTH].vld)
        else $error("transaction lost in chain");
endmodule
`default_nettype wire

/* test/floor_ceil_signed_divider_unit_checker.sv */
// checker: predicts floor/ceil division results and compares them with the outputs
`timescale 1ns / 1ps
`default_nettype none
module floor_ceil_signed_divider_unit_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [1:0]  i_func,
    input  wire logic [63:0] i_dividend,
    input  wire logic [63:0] i_divisor,
    input  wire logic        o_strobe,
    input  wire logic [63:0] o_result,
    input  wire logic [1:0]  o_status,
    output int               o_fail_count,
    output int               o_pending
);
    import fcsd_pkg::*;

    typedef struct {
        logic [63:0] result;
        logic [1:0]  status;
    } t_quot;

    t_quot quot_q[$];
    int    mismatches = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = quot_q.size();

    function automatic t_quot divide(logic [1:0] fn, logic signed [63:0] a,
                                     logic signed [63:0] b);
        t_quot             e;
        logic signed [63:0] q;
        logic signed [63:0] r;
        logic              adj;
        e.result = '0;
        e.status = ST_OK;
        if (fn == FN_RSVD) begin
            return e;
        end
        if (b == 0) begin
            e.status = ST_DIV0;
            return e;
        end
        if (a == {1'b1, 63'd0} && b == -64'sd1) begin
            if (fn != FN_FLOOR_R) begin
                e.result = {1'b0, {63{1'b1}}};
                e.status = ST_OVF;
            end
            return e;
        end
        q = a / b;
        r = a % b;
        adj = (r != 0) && ((r < 0) != (b < 0));
        case (fn)
            FN_FLOOR_Q: e.result = adj ? q - 1 : q;
            FN_FLOOR_R: e.result = adj ? r + b : r;
            default:    e.result = (r != 0 && !adj) ? q + 1 : q;
        endcase
        return e;
    endfunction

    always @(posedge i_clk) begin
        t_quot got;
        t_quot want;
        if (i_rst_n && start && !busy) begin
            quot_q.push_back(divide(i_func, i_dividend, i_divisor));
        end
        if (i_rst_n && o_strobe) begin
            got.result = o_result;
            got.status = o_status;
            if (quot_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: result %h status %0d",
                             o_result, o_status);
            end else begin
                want = quot_q.pop_front();
                if (got.result !== want.result || got.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: result %h/%h status %0d/%0d (exp/got)",
                                 want.result, got.result, want.status, got.status);
                end
            end
        end
    end
endmodule
`default_nettype wire

/* test/floor_ceil_signed_divider_unit_tb.sv */
// testbench top: drives division transactions and reports the verdict
`timescale 1ns / 1ps
`default_nettype none
module floor_ceil_signed_divider_unit_tb;
    import fcsd_pkg::*;

    localparam logic [63:0] MIN64 = {1'b1, 63'd0};
    localparam logic [63:0] MAX64 = {1'b0, {63{1'b1}}};
    localparam logic [63:0] NEG1  = '1;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic [1:0]  i_func = FN_FLOOR_Q;
    logic [63:0] i_dividend = '0;
    logic [63:0] i_divisor = '0;
    logic        busy;
    logic        o_strobe;
    logic [63:0] o_result;
    logic [1:0]  o_status;
    int          fail_count;
    int          pending;
    int          burst_left = 0;

    floor_ceil_signed_divider_unit dut (.*);

    floor_ceil_signed_divider_unit_checker chk (
        .i_clk, .i_rst_n, .start, .busy, .i_func, .i_dividend, .i_divisor,
        .o_strobe, .o_result, .o_status,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return MIN64;
            1: return MAX64;
            2: return NEG1;
            3: return 64'd1;
            4: return 64'd0;
            5: return 64'($signed($urandom_range(0, 40)) - 20);
            6: return {{32{1'b0}}, $urandom()};
            7: return {{32{$urandom_range(0, 1) == 1}}, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // one transaction, with bursts and gaps on the sender side
    task automatic send(logic [1:0] fn, logic [63:0] a, logic [63:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 4);
            if (gap > 0) begin
                start <= 0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        start      <= 1;
        i_func     <= fn;
        i_dividend <= a;
        i_divisor  <= b;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    initial begin
        logic [63:0] a;
        logic [63:0] b;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        for (int fn = 0; fn < 4; fn++) begin
            send(fn[1:0], 64'd7, 64'd2);
            send(fn[1:0], -64'sd7, 64'd2);
            send(fn[1:0], 64'd7, -64'sd2);
            send(fn[1:0], -64'sd7, -64'sd2);
            send(fn[1:0], MIN64, NEG1);
            send(fn[1:0], MAX64, 64'd0);
        end
        send(FN_FLOOR_Q, MIN64, MAX64);
        for (int n = 0; n < 1150; n++) begin
            a = pick_operand();
            b = pick_operand();
            send($urandom_range(0, 15) == 0 ? FN_RSVD : 2'($urandom_range(0, 2)), a, b);
        end
        start <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
